// File: src/brf_pkg.sv
`default_nettype none
// Shared constants, codes and types of the circular byte FIFO with statistics.
package brf_pkg;

    localparam int unsigned DEPTH   = 4096;
    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned BYTE_W  = 8;

    // Request type codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_STAT  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_WOULD_BLOCK = 2'd1;
    localparam logic [1:0] ST_BLOCKED     = 2'd2;
    localparam logic [1:0] ST_SHORT       = 2'd3;

    // Statistics selector codes
    localparam logic [1:0] SEL_WRITTEN    = 2'd0;
    localparam logic [1:0] SEL_READ       = 2'd1;
    localparam logic [1:0] SEL_WR_BLOCKED = 2'd2;
    localparam logic [1:0] SEL_RD_BLOCKED = 2'd3;

    typedef struct packed {
        logic [1:0]         status;
        logic [BYTE_W-1:0]  read_byte;
        logic [CNT_W-1:0]   stat_value;
        logic [COUNT_W-1:0] fill_level;
    } rsp_t;

endpackage
`default_nettype wire

// File: src/brf_req_if.sv
`default_nettype none
// Request channel: valid/ready handshake carrying one byte access or query.
interface brf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] write_byte;
    logic       first_of_call;
    logic       nonblock;
    logic [1:0] stat_select;

    modport source (
        output valid, req_type, write_byte, first_of_call, nonblock, stat_select,
        input  ready
    );
    modport sink (
        input  valid, req_type, write_byte, first_of_call, nonblock, stat_select,
        output ready
    );
endinterface
`default_nettype wire

// File: src/brf_rsp_if.sv
`default_nettype none
// Response channel: valid/ready handshake carrying one result item.
interface brf_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic [31:0] stat_value;
    logic [12:0] fill_level;

    modport source (
        output valid, status, read_byte, stat_value, fill_level,
        input  ready
    );
    modport sink (
        input  valid, status, read_byte, stat_value, fill_level,
        output ready
    );
endinterface
`default_nettype wire

// File: src/brf_ram.sv
`default_nettype none
// Generic single-port-write, single-port-read RAM with registered read data.
module brf_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: src/byte_ring_fifo_with_stats.sv
`default_nettype none
// Circular byte FIFO of 4096 entries with 32-bit usage statistics. Each request
// transfer is a byte write, a byte read or a statistics query, and each yields
// exactly one response transfer carrying a status, the byte read, the selected
// counter and the fill level after the request. A write to a full FIFO or a read
// from an empty one is refused: on the first byte of a call a non-blocking caller
// gets would-block, a blocking caller gets blocked and the blocked counter of
// that direction is bumped; on a later byte of a call the status is short end.
// Writes, queries and refused accesses can follow back to back; a successful read
// holds off new requests until its byte returns from the registered read port of
// the byte store. A new request is taken while a result waits in the response
// register only in the cycle that result is transferred out. The byte
// store needs no clearing after reset, since a read only ever reaches entries
// written before.
module byte_ring_fifo_with_stats (
    input  wire logic clk,
    input  wire logic rst_n,
    brf_req_if.sink   req,
    brf_rsp_if.source rsp
);

    // Pointers, fill count and statistics counters
    logic [brf_pkg::ADDR_W-1:0]  wptr_reg, wptr_next;
    logic [brf_pkg::ADDR_W-1:0]  rptr_reg, rptr_next;
    logic [brf_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [brf_pkg::CNT_W-1:0]   wr_total_reg, wr_total_next;
    logic [brf_pkg::CNT_W-1:0]   rd_total_reg, rd_total_next;
    logic [brf_pkg::CNT_W-1:0]   wr_block_reg, wr_block_next;
    logic [brf_pkg::CNT_W-1:0]   rd_block_reg, rd_block_next;

    // Read in flight: the result waits here for the store's read data
    logic                        pend_reg, pend_next;
    brf_pkg::rsp_t               hold_reg, hold_next;

    // Response register
    logic                        out_valid_reg, out_valid_next;
    brf_pkg::rsp_t               out_reg, out_next;

    logic                        accept;
    logic                        full;
    logic                        empty;
    logic                        ram_we;
    logic                        ram_re;
    logic [brf_pkg::BYTE_W-1:0]  ram_rdata;
    brf_pkg::rsp_t               res;

    // Take a request only with no read in flight and a response slot that is
    // free or draining in this cycle.
    assign req.ready = !pend_reg && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign full  = (count_reg == brf_pkg::COUNT_W'(brf_pkg::DEPTH));
    assign empty = (count_reg == '0);

    brf_ram #(
        .WIDTH (brf_pkg::BYTE_W),
        .DEPTH (brf_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (req.write_byte),
        .re    (ram_re),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        wptr_next     = wptr_reg;
        rptr_next     = rptr_reg;
        count_next    = count_reg;
        wr_total_next = wr_total_reg;
        rd_total_next = rd_total_reg;
        wr_block_next = wr_block_reg;
        rd_block_next = rd_block_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        pend_next     = 1'b0;
        res           = '0;

        if (accept)
        begin
            unique case (req.req_type)
                brf_pkg::REQ_WRITE:
                begin
                    if (full)
                    begin
                        if (!req.first_of_call)
                        begin
                            res.status = brf_pkg::ST_SHORT;
                        end
                        else if (req.nonblock)
                        begin
                            res.status = brf_pkg::ST_WOULD_BLOCK;
                        end
                        else
                        begin
                            res.status    = brf_pkg::ST_BLOCKED;
                            wr_block_next = wr_block_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        // Store the byte and advance with wrap
                        ram_we        = 1'b1;
                        wptr_next     = (wptr_reg == brf_pkg::ADDR_W'(brf_pkg::DEPTH - 1))
                                        ? '0 : wptr_reg + 1'b1;
                        count_next    = count_reg + 1'b1;
                        wr_total_next = wr_total_reg + 1'b1;
                    end
                end
                brf_pkg::REQ_READ:
                begin
                    if (empty)
                    begin
                        if (!req.first_of_call)
                        begin
                            res.status = brf_pkg::ST_SHORT;
                        end
                        else if (req.nonblock)
                        begin
                            res.status = brf_pkg::ST_WOULD_BLOCK;
                        end
                        else
                        begin
                            res.status    = brf_pkg::ST_BLOCKED;
                            rd_block_next = rd_block_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        // Launch the store read; the byte joins the result next cycle
                        ram_re        = 1'b1;
                        pend_next     = 1'b1;
                        rptr_next     = (rptr_reg == brf_pkg::ADDR_W'(brf_pkg::DEPTH - 1))
                                        ? '0 : rptr_reg + 1'b1;
                        count_next    = count_reg - 1'b1;
                        rd_total_next = rd_total_reg + 1'b1;
                    end
                end
                brf_pkg::REQ_STAT:
                begin
                    unique case (req.stat_select)
                        brf_pkg::SEL_WRITTEN:    res.stat_value = wr_total_reg;
                        brf_pkg::SEL_READ:       res.stat_value = rd_total_reg;
                        brf_pkg::SEL_WR_BLOCKED: res.stat_value = wr_block_reg;
                        brf_pkg::SEL_RD_BLOCKED: res.stat_value = rd_block_reg;
                        default:                 res.stat_value = '0;
                    endcase
                end
                default:
                begin
                    // Unused request code: no state change, plain result
                end
            endcase
        end
        res.fill_level = count_next;
    end

    // Response path: fill from the read in flight or directly from the request
    always_comb
    begin
        hold_next      = pend_next ? res : hold_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_reg)
        begin
            out_next           = hold_reg;
            out_next.read_byte = ram_rdata;
            out_valid_next     = 1'b1;
        end
        else if (accept && !pend_next)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            count_reg     <= '0;
            wr_total_reg  <= '0;
            rd_total_reg  <= '0;
            wr_block_reg  <= '0;
            rd_block_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            count_reg     <= count_next;
            wr_total_reg  <= wr_total_next;
            rd_total_reg  <= rd_total_next;
            wr_block_reg  <= wr_block_next;
            rd_block_reg  <= rd_block_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.read_byte  = out_reg.read_byte;
    assign rsp.stat_value = out_reg.stat_value;
    assign rsp.fill_level = out_reg.fill_level;

    // Fill count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= brf_pkg::COUNT_W'(brf_pkg::DEPTH))
        else $error("fill count beyond depth");

    // A read in flight always finds the response slot free
    a_pend_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !out_valid_reg)
        else $error("read completes into an occupied response slot");

    // A successful read lowers the fill count by one and leaves a read in flight that holds off new requests
    a_read_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == brf_pkg::REQ_READ && !empty)
        |=> (count_reg == $past(count_reg) - 1'b1) && pend_reg && !req.ready)
        else $error("successful read bookkeeping wrong");

    // Pointers stay in step with the fill count
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || full) |-> (wptr_reg == rptr_reg))
        else $error("pointers out of step with fill count");

endmodule
`default_nettype wire
